>>> hdl/lcsm_pkg.sv
// ============================================================================
// lcsm_pkg: shared types and constants of the load cell stability monitor
// Widths, register indexes and the flag record used by the datapath.
// ============================================================================
`default_nettype none
package lcsm_pkg;
    localparam int SampleW   = 24;
    localparam int HistW     = 25;
    localparam int SumW      = 30;
    localparam int AvgW      = 25;
    localparam int GainW     = 32;
    localparam int WeightW   = 42;
    localparam int MvW       = 22;
    localparam int CfgW      = 42;
    localparam int CfgIdxW   = 3;
    localparam int WindowDepthDefault = 32;
    localparam int StableLimit = 62;
    localparam logic [16:0] MvScale = 17'd62500;

    localparam logic [CfgIdxW-1:0] RegOffset    = 3'd0;
    localparam logic [CfgIdxW-1:0] RegZeroPoint = 3'd1;
    localparam logic [CfgIdxW-1:0] RegGain      = 3'd2;
    localparam logic [CfgIdxW-1:0] RegCapacity  = 3'd3;
    localparam logic [CfgIdxW-1:0] RegZeroBand  = 3'd4;

    typedef struct packed {
        logic stable;
        logic ev_zero;
        logic ev_stable;
        logic ev_unstable;
        logic ev_overload;
    } lcsm_flags_t;
endpackage
`default_nettype wire

>>> hdl/lcsm_serial_mul.sv
// ============================================================================
// lcsm_serial_mul: bit-serial signed multiplier
// Shift-and-add over the multiplier bits, one bit per cycle.
// ============================================================================
`default_nettype none
module lcsm_serial_mul
    import lcsm_pkg::*;
#(
    parameter int AW = 26,
    parameter int BW = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [AW-1:0] a,
    input  wire logic signed [BW-1:0] b,
    output logic                      done,
    output logic signed [AW+BW-1:0]   product
);
    localparam int CntW = $clog2(BW + 1);
    logic [CntW-1:0]           cnt_reg;
    logic                      busy_reg;
    logic signed [AW+BW-1:0]   acc_reg;
    logic signed [AW+BW-1:0]   mcand_reg;
    logic [BW-1:0]             mplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntW'(BW - 1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= (AW+BW)'(a);
            mplier_reg <= b;
        end
        else if (busy_reg)
        begin
            // The top bit of a two's complement multiplier has negative weight.
            if (mplier_reg[0])
            begin
                if (cnt_reg == CntW'(BW - 1))
                    acc_reg <= acc_reg - mcand_reg;
                else
                    acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign product = acc_reg;
endmodule
`default_nettype wire

>>> hdl/lcsm_var_walk.sv
// ============================================================================
// lcsm_var_walk: squared deviation walk over the sample ring
// Reads the ring entries one after another, each through a read state and an
// accumulate state, and accumulates its squared deviation.
`default_nettype none
module lcsm_var_walk
    import lcsm_pkg::*;
#(
    parameter int WINDOW_DEPTH = WindowDepthDefault
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic signed [AvgW-1:0] avg,
    input  wire logic signed [HistW-1:0] rd_data,
    output logic [$clog2(WINDOW_DEPTH)-1:0] rd_addr,
    output logic                       done,
    output logic                       stable
);
    localparam int IdxW = $clog2(WINDOW_DEPTH);
    typedef enum logic [1:0] {S_IDLE, S_READ, S_ACC} walk_state_t;
    walk_state_t state_reg;
    logic [IdxW:0]  cnt_reg;
    logic [6:0]     sq_reg;     // saturating at the stable limit
    logic           over_reg;
    logic signed [HistW:0] dev;
    logic [HistW:0] mag;
    logic [13:0]    sq_small;
    logic [7:0]     sum_next;

    assign dev = (HistW+1)'(rd_data) - (HistW+1)'(avg);
    assign mag = dev[HistW] ? -dev : dev;
    // Any magnitude of 8 or more already exceeds the limit on its own.
    assign sq_small = 14'(mag[6:0]) * 14'(mag[6:0]);
    assign sum_next = 8'(sq_reg) + 8'(sq_small[6:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            sq_reg    <= '0;
            over_reg  <= 1'b0;
            done      <= 1'b0;
            stable    <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cnt_reg   <= '0;
                        sq_reg    <= '0;
                        over_reg  <= 1'b0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (mag > (HistW+1)'(7) || sq_small > 14'd63 ||
                        sum_next >= 8'(StableLimit))
                        over_reg <= 1'b1;
                    else
                        sq_reg <= sum_next[6:0];
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (IdxW+1)'(WINDOW_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                        done      <= 1'b1;
                        stable    <= !(over_reg || mag > (HistW+1)'(7) ||
                                       sq_small > 14'd63 ||
                                       sum_next >= 8'(StableLimit));
                    end
                    else
                        state_reg <= S_READ;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rd_addr = cnt_reg[IdxW-1:0];
endmodule
`default_nettype wire

>>> hdl/load_cell_stability_monitor_top.sv
// ============================================================================
// load_cell_stability_monitor_top: moving average stability monitor
// Offset correction, 32-entry ring average, variance test, weight and events.
// ============================================================================
// Each sample item is offset-corrected and written into a ring of the last
// WINDOW_DEPTH corrected samples, with a running sum kept alongside. The
// average is the sum divided by the depth, truncated toward zero. A walk over
// the ring then sums squared deviations from the average, one entry at a time
// through the ring's single registered read port, and the reading is
// stable when that sum stays below 62. In parallel a bit-serial multiplier
// forms the weight (average minus zero point times the Q16.16 gain, one gain
// bit per cycle) and a second one the mV/V figure. The block takes one item
// at a time. The result item sits in an output register, and the next item is
// taken once that register is free or being emptied. The ring starts at all
// zero out of reset with no clearing pass: valid bits mark entries not yet
// written, which read as zero. Configuration is written through a plain write
// port; the user must write it only while the block idles, which the block
// itself does not enforce.
`default_nettype none
module load_cell_stability_monitor_top
    import lcsm_pkg::*;
#(
    parameter int WINDOW_DEPTH = WindowDepthDefault
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CfgIdxW-1:0]        cfg_index,
    input  wire logic [CfgW-1:0]           cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [SampleW-1:0] sample,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [AvgW-1:0]         average,
    output logic signed [WeightW-1:0]      weight,
    output logic                           stable,
    output logic                           event_zero,
    output logic                           event_stable,
    output logic                           event_unstable,
    output logic                           event_overload,
    output logic signed [MvW-1:0]          millivolt_ratio
);
    localparam int IdxW   = $clog2(WINDOW_DEPTH);
    localparam int DiffW  = AvgW + 1;
    localparam int ProdW  = DiffW + GainW;
    localparam int MvProdW = AvgW + 18;

    typedef enum logic [2:0] {S_IDLE, S_RDOLD, S_UPD, S_WORK, S_FLAGS} ctl_state_t;

    // Configuration registers.
    logic signed [SampleW-1:0] offset_reg;
    logic signed [AvgW-1:0]    zero_point_reg;
    logic signed [GainW-1:0]   gain_reg;
    logic signed [WeightW-1:0] capacity_reg;
    logic [SampleW-1:0]        zero_band_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= '0;
            zero_point_reg <= '0;
            gain_reg       <= '0;
            capacity_reg   <= '0;
            zero_band_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegOffset:    offset_reg     <= cfg_data[SampleW-1:0];
                RegZeroPoint: zero_point_reg <= cfg_data[AvgW-1:0];
                RegGain:      gain_reg       <= cfg_data[GainW-1:0];
                RegCapacity:  capacity_reg   <= cfg_data[WeightW-1:0];
                RegZeroBand:  zero_band_reg  <= cfg_data[SampleW-1:0];
                default: ;
            endcase
        end
    end

    // Sample ring with one read port; unwritten entries read as zero.
    logic signed [HistW-1:0] ring_mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] ring_valid_reg;
    logic signed [HistW-1:0] ring_q_reg;
    logic                    ring_q_valid_reg;
    logic [IdxW-1:0]         ring_raddr;
    logic                    ring_we;
    logic signed [HistW-1:0] ring_rd;

    ctl_state_t              state_reg;
    logic [IdxW-1:0]         widx_reg;
    logic signed [HistW-1:0] corr_reg;
    logic signed [SumW-1:0]  sum_reg;
    logic signed [SumW-1:0]  sum_new;
    logic signed [AvgW-1:0]  avg_reg;
    logic                    stable_rep_reg;
    logic                    unstable_rep_reg;
    logic                    overload_rep_reg;
    logic                    walk_start;
    logic                    walk_done;
    logic                    walk_stable;
    logic                    walk_seen_reg;
    logic                    stable_hold_reg;
    logic [IdxW-1:0]         walk_addr;
    logic                    mul_start;
    logic                    wmul_done;
    logic                    mmul_done;
    logic                    wmul_seen_reg;
    logic                    mmul_seen_reg;
    logic signed [ProdW-1:0] wprod;
    logic signed [MvProdW-1:0] mprod;
    logic signed [DiffW-1:0] diff_reg;

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[widx_reg] <= corr_reg;
        ring_q_reg <= ring_mem[ring_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_valid_reg   <= '0;
            ring_q_valid_reg <= 1'b0;
        end
        else
        begin
            if (ring_we)
                ring_valid_reg[widx_reg] <= 1'b1;
            ring_q_valid_reg <= ring_valid_reg[ring_raddr];
        end
    end

    assign ring_rd    = ring_q_valid_reg ? ring_q_reg : '0;
    assign ring_raddr = (state_reg == S_WORK) ? walk_addr : widx_reg;
    assign ring_we    = (state_reg == S_UPD);
    assign sum_new    = sum_reg - SumW'(ring_rd) + SumW'(corr_reg);

    // Signed division by the power-of-two depth, truncated toward zero.
    function automatic logic signed [AvgW-1:0] div_depth(input logic signed [SumW-1:0] s);
        logic signed [SumW-1:0] adj;
        adj = s + (s[SumW-1] ? SumW'(WINDOW_DEPTH - 1) : SumW'(0));
        return AvgW'(adj >>> IdxW);
    endfunction

    assign walk_start = (state_reg == S_UPD);
    assign mul_start  = (state_reg == S_UPD);

    // The walk reads the average registered at its start; it also sees the
    // new entry, since the ring write lands in the same edge as the walk starts.
    lcsm_var_walk #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (walk_start),
        .avg     (avg_reg),
        .rd_data (ring_rd),
        .rd_addr (walk_addr),
        .done    (walk_done),
        .stable  (walk_stable)
    );

    lcsm_serial_mul #(.AW(DiffW), .BW(GainW)) u_wmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (DiffW'(div_depth(sum_new)) - DiffW'(zero_point_reg)),
        .b       (gain_reg),
        .done    (wmul_done),
        .product (wprod)
    );

    lcsm_serial_mul #(.AW(AvgW), .BW(18)) u_mmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (div_depth(sum_new)),
        .b       (18'(MvScale)),
        .done    (mmul_done),
        .product (mprod)
    );

    // Final flag logic over registered products.
    logic signed [WeightW-1:0] w_calc;
    logic signed [MvW-1:0]     mv_calc;
    logic [ProdW-1:0]          wp_adj;
    logic [MvProdW-1:0]        mp_adj;
    lcsm_flags_t               fl;
    logic signed [WeightW-1:0] w_final;
    logic                      srep_n, urep_n, orep_n;

    always_comb
    begin
        wp_adj  = wprod + (wprod[ProdW-1] ? ProdW'(65535) : ProdW'(0));
        w_calc  = WeightW'($signed(wp_adj) >>> 16);
        mp_adj  = mprod + (mprod[MvProdW-1] ? MvProdW'(524287) : MvProdW'(0));
        mv_calc = MvW'($signed(mp_adj) >>> 19);
        fl      = '0;
        fl.stable = stable_hold_reg;
        w_final = w_calc;
        srep_n  = stable_rep_reg;
        urep_n  = unstable_rep_reg;
        orep_n  = overload_rep_reg;
        if (stable_hold_reg)
        begin
            if (!stable_rep_reg)
            begin
                if (diff_reg[SampleW-1:0] <= zero_band_reg)
                begin
                    w_final    = '0;
                    fl.ev_zero = 1'b1;
                end
                else
                    fl.ev_stable = 1'b1;
                srep_n = 1'b1;
                urep_n = 1'b0;
                orep_n = 1'b0;
            end
        end
        else if (!unstable_rep_reg)
        begin
            urep_n = 1'b1;
            srep_n = 1'b0;
            orep_n = 1'b0;
            fl.ev_unstable = 1'b1;
        end
        if (w_final >= capacity_reg && !orep_n)
        begin
            orep_n = 1'b1;
            srep_n = 1'b0;
            urep_n = 1'b0;
            fl.ev_overload = 1'b1;
        end
    end

    // No item is taken while reset is held.
    assign in_stall = !rst_n || (state_reg != S_IDLE) || (out_valid && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            widx_reg         <= '0;
            sum_reg          <= '0;
            stable_rep_reg   <= 1'b0;
            unstable_rep_reg <= 1'b0;
            overload_rep_reg <= 1'b0;
            walk_seen_reg    <= 1'b0;
            wmul_seen_reg    <= 1'b0;
            mmul_seen_reg    <= 1'b0;
            stable_hold_reg  <= 1'b0;
            out_valid        <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                out_valid <= 1'b0;
            if (walk_done)
            begin
                walk_seen_reg   <= 1'b1;
                stable_hold_reg <= walk_stable;
            end
            if (wmul_done)
                wmul_seen_reg <= 1'b1;
            if (mmul_done)
                mmul_seen_reg <= 1'b1;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                        state_reg <= S_RDOLD;
                end
                S_RDOLD: state_reg <= S_UPD;
                S_UPD:
                begin
                    sum_reg       <= sum_new;
                    widx_reg      <= widx_reg + 1'b1;
                    walk_seen_reg <= 1'b0;
                    wmul_seen_reg <= 1'b0;
                    mmul_seen_reg <= 1'b0;
                    state_reg     <= S_WORK;
                end
                S_WORK:
                begin
                    if (walk_seen_reg && wmul_seen_reg && mmul_seen_reg)
                        state_reg <= S_FLAGS;
                end
                S_FLAGS:
                begin
                    stable_rep_reg   <= srep_n;
                    unstable_rep_reg <= urep_n;
                    overload_rep_reg <= orep_n;
                    out_valid        <= 1'b1;
                    state_reg        <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && !in_stall)
            corr_reg <= HistW'(sample) - HistW'(offset_reg);
        if (state_reg == S_UPD)
        begin
            avg_reg  <= div_depth(sum_new);
            diff_reg <= DiffW'(div_depth(sum_new)) - DiffW'(zero_point_reg);
        end
        if (state_reg == S_FLAGS)
        begin
            average         <= avg_reg;
            weight          <= w_final;
            stable          <= fl.stable;
            event_zero      <= fl.ev_zero;
            event_stable    <= fl.ev_stable;
            event_unstable  <= fl.ev_unstable;
            event_overload  <= fl.ev_overload;
            millivolt_ratio <= mv_calc;
        end
    end
endmodule
`default_nettype wire
